[src/tbi_pkg.sv]
// Shared types, constants and register codes for the three-band isolator.
`timescale 1ns / 1ps

package tbi_pkg;

   // Defaults for the top-level parameters
   localparam int SAMPLE_WIDTH_DEFAULT   = 24;
   localparam int COEF_FRAC_BITS_DEFAULT = 22;

   // Fixed formats
   localparam int MAX_CHANNELS    = 2;
   localparam int STATE_WIDTH     = 40;
   localparam int X_WIDTH         = STATE_WIDTH - 2;   // sample moved up to state scale
   localparam int MUL_B_WIDTH     = STATE_WIDTH + 2;   // widest multiplicand (mid band)
   localparam int SPLIT           = MUL_B_WIDTH / 2;   // low/high halves of the multiplicand
   localparam int GAIN_WIDTH      = 17;
   localparam int GAIN_FRAC       = 16;
   localparam int COEF_WIDTH      = 24;
   localparam int COUNT_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 24;

   // Register reset values
   localparam logic [GAIN_WIDTH-1:0]         GAIN_UNITY    = 17'd65536;
   localparam logic signed [COEF_WIDTH-1:0]  LOW_A1_RESET  = -24'sd8135163;
   localparam logic signed [COEF_WIDTH-1:0]  LOW_A2_RESET  = 24'sd3948292;
   localparam logic signed [COEF_WIDTH-1:0]  HIGH_A1_RESET = -24'sd5903554;
   localparam logic signed [COEF_WIDTH-1:0]  HIGH_A2_RESET = 24'sd2292820;

   // Channel count codes
   localparam logic [COUNT_WIDTH-1:0] CH_NONE   = 2'd0;
   localparam logic [COUNT_WIDTH-1:0] CH_MONO   = 2'd1;
   localparam logic [COUNT_WIDTH-1:0] CH_STEREO = 2'd2;

   // Register indexes on the CSR port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_LOW_GAIN      = 4'd0,
      REG_MID_GAIN      = 4'd1,
      REG_HIGH_GAIN     = 4'd2,
      REG_LOW_A1        = 4'd3,
      REG_LOW_A2        = 4'd4,
      REG_HIGH_A1       = 4'd5,
      REG_HIGH_A2       = 4'd6,
      REG_CHANNEL_COUNT = 4'd7
   } reg_index_type;

   // Multiply operations, in issue order
   localparam int OP_COUNT   = 9;
   localparam int STEP_COUNT = 2 * OP_COUNT;
   localparam int STEP_WIDTH = $clog2(STEP_COUNT);

   typedef enum logic [STEP_WIDTH-2:0] {
      OP_LOW_FF    = 4'd0,   // b0 * x for the low-pass
      OP_HIGH_FF   = 4'd1,   // b0 * x for the high-pass
      OP_LOW_A1    = 4'd2,
      OP_LOW_A2    = 4'd3,
      OP_HIGH_A1   = 4'd4,
      OP_HIGH_A2   = 4'd5,
      OP_GAIN_LOW  = 4'd6,
      OP_GAIN_MID  = 4'd7,
      OP_GAIN_HIGH = 4'd8
   } op_type;

   // Sequencer state
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_FINISH
   } seq_state_type;

   // Control word from the sequencer to every lane
   typedef struct packed {
      logic   start;    // latch the request sample and coefficient sums
      logic   mac_en;   // multiply-accumulate this cycle
      op_type op;       // operation being multiplied
      logic   hi;       // upper half of the multiplicand
      logic   fin_en;   // retire the previous operation
      op_type fin_op;   // operation being retired
   } ctrl_type;

endpackage

[src/tbi_ctrl.sv]
// Sequencer: steps both lanes through the nine two-pass multiplies of a frame.
`timescale 1ns / 1ps

module tbi_ctrl import tbi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     out_free,
   output logic     req_stall,
   output logic     out_load,
   output ctrl_type ctrl
);

   seq_state_type state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(STEP_COUNT - 1);

   // Next state and step counter
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         SEQ_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (step_ff == LAST_STEP) begin
               state_in = SEQ_FINISH;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         SEQ_FINISH: begin
            if (out_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall   = 1'b1;
      out_load    = 1'b0;
      ctrl.start  = 1'b0;
      ctrl.mac_en = 1'b0;
      ctrl.op     = op_type'(step_ff[STEP_WIDTH-1:1]);
      ctrl.hi     = step_ff[0];
      ctrl.fin_en = 1'b0;
      ctrl.fin_op = op_type'(step_ff[STEP_WIDTH-1:1] - 1'b1);
      case (state_ff)
         SEQ_IDLE: begin
            req_stall  = 1'b0;
            ctrl.start = req_valid;
         end
         SEQ_RUN: begin
            ctrl.mac_en = 1'b1;
            // the first pass of each op retires the one before it
            ctrl.fin_en = !step_ff[0] && (step_ff != '0);
         end
         SEQ_FINISH: begin
            out_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[src/tbi_lane.sv]
// One channel lane: low-pass and high-pass biquads and band recombination on one MAC.
`timescale 1ns / 1ps

module tbi_lane import tbi_pkg::*; #(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEFAULT,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctrl_type                       ctrl,
   input  logic                           active,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   input  logic [GAIN_WIDTH-1:0]          low_gain,
   input  logic [GAIN_WIDTH-1:0]          mid_gain,
   input  logic [GAIN_WIDTH-1:0]          high_gain,
   input  logic signed [COEF_WIDTH-1:0]   low_a1,
   input  logic signed [COEF_WIDTH-1:0]   low_a2,
   input  logic signed [COEF_WIDTH-1:0]   high_a1,
   input  logic signed [COEF_WIDTH-1:0]   high_a2,
   output logic signed [SAMPLE_WIDTH-1:0] sample_out,
   output logic signed [SAMPLE_WIDTH-1:0] result_out
);

   localparam int STATE_FRAC = STATE_WIDTH - SAMPLE_WIDTH - 2;
   localparam int AW =
      ((COEF_FRAC_BITS > COEF_WIDTH) ? COEF_FRAC_BITS : COEF_WIDTH) + 2;
   localparam int ACC_W     = AW + MUL_B_WIDTH + 2;
   localparam int BAND_W    = AW + X_WIDTH - COEF_FRAC_BITS - 2;
   localparam int OUT_SHIFT = GAIN_FRAC + STATE_FRAC;

   localparam logic signed [AW-1:0]    COEF_ONE  = AW'(1) << COEF_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] BIAS_BAND = ACC_W'(1) << (COEF_FRAC_BITS + 1);
   localparam logic signed [ACC_W-1:0] BIAS_FB   = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] BIAS_OUT  = ACC_W'(1) << (OUT_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] ST_MAX =
      ACC_W'((longint'(1) <<< (STATE_WIDTH - 1)) - 1);
   localparam logic signed [ACC_W-1:0] ST_MIN = ~ST_MAX;
   localparam logic signed [ACC_W-1:0] SMP_MAX =
      ACC_W'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;

   function automatic logic signed [STATE_WIDTH-1:0] sat_state(
      input logic signed [ACC_W-1:0] v
   );
      logic signed [STATE_WIDTH-1:0] r;
      if (v > ST_MAX) begin
         r = ST_MAX[STATE_WIDTH-1:0];
      end else if (v < ST_MIN) begin
         r = ST_MIN[STATE_WIDTH-1:0];
      end else begin
         r = v[STATE_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v
   );
      logic signed [SAMPLE_WIDTH-1:0] r;
      if (v > SMP_MAX) begin
         r = SMP_MAX[SAMPLE_WIDTH-1:0];
      end else if (v < SMP_MIN) begin
         r = SMP_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         r = v[SAMPLE_WIDTH-1:0];
      end
      return r;
   endfunction

   // Per-request registers
   logic signed [X_WIDTH-1:0]     x_ff, x_in;
   logic signed [AW-1:0]          lsum_ff, lsum_in, hsum_ff, hsum_in;
   logic signed [BAND_W-1:0]      lb_ff, lb_in, hb_ff, hb_in;
   logic signed [STATE_WIDTH-1:0] low_ff, low_in, high_ff, high_in;
   logic signed [MUL_B_WIDTH-1:0] mid_ff, mid_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;

   // Filter state, kept across requests
   logic signed [STATE_WIDTH-1:0] lp_s1_ff, lp_s1_in, lp_s2_ff, lp_s2_in;
   logic signed [STATE_WIDTH-1:0] hp_s1_ff, hp_s1_in, hp_s2_ff, hp_s2_in;

   // Multiplier operands
   logic signed [AW-1:0]          a_op;
   logic signed [MUL_B_WIDTH-1:0] b_op;
   logic signed [ACC_W-1:0]       bias;
   logic                          clear;
   logic signed [SPLIT:0]         mb;
   logic signed [AW+SPLIT:0]      prod;
   logic signed [ACC_W-1:0]       addend;

   // Rounded views of the finished accumulator
   logic signed [ACC_W-1:0] sh_band, sh_fb, sh_out;

   // Request latch: sample at state scale, feed-forward coefficient sums
   always_comb begin
      x_in    = x_ff;
      lsum_in = lsum_ff;
      hsum_in = hsum_ff;
      if (ctrl.start) begin
         x_in    = {sample_in, {STATE_FRAC{1'b0}}};
         lsum_in = COEF_ONE + AW'(low_a1) + AW'(low_a2);
         hsum_in = COEF_ONE - AW'(high_a1) + AW'(high_a2);
      end
   end

   // Operand selection per operation
   always_comb begin
      a_op  = '0;
      b_op  = '0;
      bias  = BIAS_FB;
      clear = !ctrl.hi;
      case (ctrl.op)
         OP_LOW_FF: begin
            a_op = lsum_ff;
            b_op = MUL_B_WIDTH'(x_ff);
            bias = BIAS_BAND;
         end
         OP_HIGH_FF: begin
            a_op = hsum_ff;
            b_op = MUL_B_WIDTH'(x_ff);
            bias = BIAS_BAND;
         end
         OP_LOW_A1: begin
            a_op = AW'(low_a1);
            b_op = MUL_B_WIDTH'(low_ff);
         end
         OP_LOW_A2: begin
            a_op = AW'(low_a2);
            b_op = MUL_B_WIDTH'(low_ff);
         end
         OP_HIGH_A1: begin
            a_op = AW'(high_a1);
            b_op = MUL_B_WIDTH'(high_ff);
         end
         OP_HIGH_A2: begin
            a_op = AW'(high_a2);
            b_op = MUL_B_WIDTH'(high_ff);
         end
         OP_GAIN_LOW: begin
            a_op = AW'($signed({1'b0, low_gain}));
            b_op = MUL_B_WIDTH'(low_ff);
            bias = BIAS_OUT;
         end
         OP_GAIN_MID: begin
            // keeps accumulating onto the low band term
            a_op  = AW'($signed({1'b0, mid_gain}));
            b_op  = mid_ff;
            clear = 1'b0;
         end
         OP_GAIN_HIGH: begin
            a_op  = AW'($signed({1'b0, high_gain}));
            b_op  = MUL_B_WIDTH'(high_ff);
            clear = 1'b0;
         end
         default: begin
            clear = 1'b0;
         end
      endcase
   end

   // Two-pass multiply-accumulate: unsigned low half, then signed high half
   always_comb begin
      if (ctrl.hi) begin
         mb = {b_op[MUL_B_WIDTH-1], b_op[MUL_B_WIDTH-1:SPLIT]};
      end else begin
         mb = {1'b0, b_op[SPLIT-1:0]};
      end
      prod = a_op * mb;
      if (ctrl.hi) begin
         addend = ACC_W'(prod) <<< SPLIT;
      end else begin
         addend = ACC_W'(prod);
      end
      acc_in = acc_ff;
      if (ctrl.mac_en) begin
         acc_in = (clear ? bias : acc_ff) + addend;
      end
   end

   assign sh_band = acc_ff >>> (COEF_FRAC_BITS + 2);
   assign sh_fb   = acc_ff >>> COEF_FRAC_BITS;
   assign sh_out  = acc_ff >>> OUT_SHIFT;

   // Retire the previous operation: band values and state updates
   always_comb begin
      lb_in    = lb_ff;
      hb_in    = hb_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      mid_in   = mid_ff;
      lp_s1_in = lp_s1_ff;
      lp_s2_in = lp_s2_ff;
      hp_s1_in = hp_s1_ff;
      hp_s2_in = hp_s2_ff;
      if (ctrl.fin_en) begin
         case (ctrl.fin_op)
            OP_LOW_FF: begin
               lb_in  = sh_band[BAND_W-1:0];
               low_in = sat_state(sh_band + ACC_W'(lp_s1_ff));
            end
            OP_HIGH_FF: begin
               hb_in   = sh_band[BAND_W-1:0];
               high_in = sat_state(sh_band + ACC_W'(hp_s1_ff));
            end
            OP_LOW_A1: begin
               mid_in = MUL_B_WIDTH'(x_ff) - MUL_B_WIDTH'(low_ff) - MUL_B_WIDTH'(high_ff);
               if (active) begin
                  lp_s1_in = sat_state((ACC_W'(lb_ff) <<< 1) - sh_fb + ACC_W'(lp_s2_ff));
               end
            end
            OP_LOW_A2: begin
               if (active) begin
                  lp_s2_in = sat_state(ACC_W'(lb_ff) - sh_fb);
               end
            end
            OP_HIGH_A1: begin
               if (active) begin
                  hp_s1_in = sat_state(-(ACC_W'(hb_ff) <<< 1) - sh_fb + ACC_W'(hp_s2_ff));
               end
            end
            OP_HIGH_A2: begin
               if (active) begin
                  hp_s2_in = sat_state(ACC_W'(hb_ff) - sh_fb);
               end
            end
            default: begin
               // gain terms only accumulate
            end
         endcase
      end
   end

   assign sample_out = x_ff[X_WIDTH-1 -: SAMPLE_WIDTH];
   assign result_out = sat_sample(sh_out);

   // Datapath registers
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      lsum_ff <= lsum_in;
      hsum_ff <= hsum_in;
      lb_ff   <= lb_in;
      hb_ff   <= hb_in;
      low_ff  <= low_in;
      high_ff <= high_in;
      mid_ff  <= mid_in;
      acc_ff  <= acc_in;
   end

   // Filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         lp_s1_ff <= '0;
         lp_s2_ff <= '0;
         hp_s1_ff <= '0;
         hp_s2_ff <= '0;
      end else begin
         lp_s1_ff <= lp_s1_in;
         lp_s2_ff <= lp_s2_in;
         hp_s1_ff <= hp_s1_in;
         hp_s2_ff <= hp_s2_in;
      end
   end

endmodule

[src/tbi_merge.sv]
// Merge stage: picks lane results by channel mode and holds the response register.
`timescale 1ns / 1ps

module tbi_merge import tbi_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           out_load,
   input  logic [COUNT_WIDTH-1:0]         channel_count,
   input  logic signed [SAMPLE_WIDTH-1:0] lane_result [MAX_CHANNELS],
   input  logic signed [SAMPLE_WIDTH-1:0] lane_sample [MAX_CHANNELS],
   input  logic                           rsp_stall,
   output logic                           out_free,
   output logic                           rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_right_out
);

   logic                           valid_ff, valid_in;
   logic signed [SAMPLE_WIDTH-1:0] left_ff, left_in, right_ff, right_in;
   logic signed [SAMPLE_WIDTH-1:0] left_sel, right_sel;

   // Channel mode selection
   always_comb begin
      case (channel_count)
         CH_NONE: begin
            left_sel  = lane_sample[0];
            right_sel = lane_sample[1];
         end
         CH_MONO: begin
            left_sel  = lane_result[0];
            right_sel = lane_result[0];
         end
         default: begin
            left_sel  = lane_result[0];
            right_sel = lane_result[1];
         end
      endcase
   end

   // Response register
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      left_in  = left_ff;
      right_in = right_ff;
      if (out_load) begin
         valid_in = 1'b1;
         left_in  = left_sel;
         right_in = right_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;

endmodule

[src/three_band_isolator.sv]
// Top level of the three-band isolator: CSR bank, sequencer, two channel lanes, merge.
`timescale 1ns / 1ps

// Each lane issues nine multiplies (two biquad feed-forward terms, four feedback
// terms, three band gains), and each multiply makes two passes through the lane's
// single multiplier, one per half of the 42-bit operand; the result is then loaded
// into the response register. The left and right lanes run in lockstep, so stereo,
// mono and pass-through frames all take the same time. A new request is taken
// the cycle after the response is loaded, even if that response is still stalled,
// so no new request is accepted while a frame is still being processed.
// In mono mode the right-channel filter state is left untouched; with a channel
// count of zero the samples pass through and no state changes.

module three_band_isolator import tbi_pkg::*; #(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEFAULT,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_left_in,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_right_in,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_right_out,
   // CSR write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]        csr_data
);

   // Configuration registers
   logic [GAIN_WIDTH-1:0]        low_gain_ff, low_gain_in;
   logic [GAIN_WIDTH-1:0]        mid_gain_ff, mid_gain_in;
   logic [GAIN_WIDTH-1:0]        high_gain_ff, high_gain_in;
   logic signed [COEF_WIDTH-1:0] low_a1_ff, low_a1_in, low_a2_ff, low_a2_in;
   logic signed [COEF_WIDTH-1:0] high_a1_ff, high_a1_in, high_a2_ff, high_a2_in;
   logic [COUNT_WIDTH-1:0]       channel_count_ff, channel_count_in;

   ctrl_type ctrl;
   logic     out_load;
   logic     out_free;

   logic signed [SAMPLE_WIDTH-1:0] lane_in     [MAX_CHANNELS];
   logic signed [SAMPLE_WIDTH-1:0] lane_result [MAX_CHANNELS];
   logic signed [SAMPLE_WIDTH-1:0] lane_sample [MAX_CHANNELS];

   assign csr_ready = 1'b1;

   // CSR writes; unknown indexes are dropped
   always_comb begin
      low_gain_in      = low_gain_ff;
      mid_gain_in      = mid_gain_ff;
      high_gain_in     = high_gain_ff;
      low_a1_in        = low_a1_ff;
      low_a2_in        = low_a2_ff;
      high_a1_in       = high_a1_ff;
      high_a2_in       = high_a2_ff;
      channel_count_in = channel_count_ff;
      if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_LOW_GAIN:      low_gain_in      = csr_data[GAIN_WIDTH-1:0];
            REG_MID_GAIN:      mid_gain_in      = csr_data[GAIN_WIDTH-1:0];
            REG_HIGH_GAIN:     high_gain_in     = csr_data[GAIN_WIDTH-1:0];
            REG_LOW_A1:        low_a1_in        = csr_data[COEF_WIDTH-1:0];
            REG_LOW_A2:        low_a2_in        = csr_data[COEF_WIDTH-1:0];
            REG_HIGH_A1:       high_a1_in       = csr_data[COEF_WIDTH-1:0];
            REG_HIGH_A2:       high_a2_in       = csr_data[COEF_WIDTH-1:0];
            REG_CHANNEL_COUNT: channel_count_in = csr_data[COUNT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_gain_ff      <= GAIN_UNITY;
         mid_gain_ff      <= GAIN_UNITY;
         high_gain_ff     <= GAIN_UNITY;
         low_a1_ff        <= LOW_A1_RESET;
         low_a2_ff        <= LOW_A2_RESET;
         high_a1_ff       <= HIGH_A1_RESET;
         high_a2_ff       <= HIGH_A2_RESET;
         channel_count_ff <= CH_STEREO;
      end else begin
         low_gain_ff      <= low_gain_in;
         mid_gain_ff      <= mid_gain_in;
         high_gain_ff     <= high_gain_in;
         low_a1_ff        <= low_a1_in;
         low_a2_ff        <= low_a2_in;
         high_a1_ff       <= high_a1_in;
         high_a2_ff       <= high_a2_in;
         channel_count_ff <= channel_count_in;
      end
   end

   // Sequencer
   tbi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_stall (req_stall),
      .out_load  (out_load),
      .ctrl      (ctrl)
   );

   // Channel lanes
   assign lane_in[0] = req_left_in;
   assign lane_in[1] = req_right_in;

   for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
      tbi_lane #(
         .SAMPLE_WIDTH   (SAMPLE_WIDTH),
         .COEF_FRAC_BITS (COEF_FRAC_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .active     (channel_count_ff > COUNT_WIDTH'(i)),
         .sample_in  (lane_in[i]),
         .low_gain   (low_gain_ff),
         .mid_gain   (mid_gain_ff),
         .high_gain  (high_gain_ff),
         .low_a1     (low_a1_ff),
         .low_a2     (low_a2_ff),
         .high_a1    (high_a1_ff),
         .high_a2    (high_a2_ff),
         .sample_out (lane_sample[i]),
         .result_out (lane_result[i])
      );
   end

   // Merge and response register
   tbi_merge #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .out_load      (out_load),
      .channel_count (channel_count_ff),
      .lane_result   (lane_result),
      .lane_sample   (lane_sample),
      .rsp_stall     (rsp_stall),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

   // A taken request keeps the request side stalled while the lanes work
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while lanes still busy");

   // The response register is loaded only when its old contents are gone
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten before it was taken");

   // A loaded result is offered on the next cycle
   a_valid_after_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("loaded response not offered");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the three-band isolator: directed and random frames checked against a model.
`timescale 1ns / 1ps

module testbench;
   import tbi_pkg::*;

   localparam int SW          = SAMPLE_WIDTH_DEFAULT;
   localparam int CFB         = COEF_FRAC_BITS_DEFAULT;
   localparam int STATE_FRAC  = STATE_WIDTH - SW - 2;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 100;
   localparam int ONE_COEF    = 1 << CFB;
   localparam int A2_SPAN     = ONE_COEF - 194304;

   localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
   localparam logic [GAIN_WIDTH-1:0] GAIN_MAX = {GAIN_WIDTH{1'b1}};
   // count of three is decoded as stereo
   localparam logic [COUNT_WIDTH-1:0] CH_STEREO_ALIAS = CH_STEREO | CH_MONO;

   typedef struct packed {
      logic signed [SW-1:0] left;
      logic signed [SW-1:0] right;
   } frame_type;

   // DUT ports
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SW-1:0] req_left_in = '0;
   logic signed [SW-1:0] req_right_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SW-1:0] rsp_left_out;
   logic signed [SW-1:0] rsp_right_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   // model copy of the register bank
   logic [GAIN_WIDTH-1:0] gain_low = GAIN_UNITY;
   logic [GAIN_WIDTH-1:0] gain_mid = GAIN_UNITY;
   logic [GAIN_WIDTH-1:0] gain_high = GAIN_UNITY;
   logic signed [COEF_WIDTH-1:0] low_a1 = LOW_A1_RESET;
   logic signed [COEF_WIDTH-1:0] low_a2 = LOW_A2_RESET;
   logic signed [COEF_WIDTH-1:0] high_a1 = HIGH_A1_RESET;
   logic signed [COEF_WIDTH-1:0] high_a2 = HIGH_A2_RESET;
   logic [COUNT_WIDTH-1:0] channel_count = CH_STEREO;

   // model copy of the filter state, per channel
   longint lp_z1[MAX_CHANNELS] = '{0, 0};
   longint lp_z2[MAX_CHANNELS] = '{0, 0};
   longint hp_z1[MAX_CHANNELS] = '{0, 0};
   longint hp_z2[MAX_CHANNELS] = '{0, 0};

   frame_type pending_requests[$];
   frame_type predicted_frames[$];
   int request_count = 0;
   int response_count = 0;
   int error_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   three_band_isolator uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #6 clock = ~clock;

   function automatic longint sat_to(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   // arithmetic shift right with round half up
   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // one channel through both biquads and the gain recombination; updates state
   function automatic logic signed [SW-1:0] isolate_channel(int ch, longint x);
      longint one, xs, la1, la2, ha1, ha2, lb, hb, low, high, mid, acc;
      one = longint'(1) <<< CFB;
      xs  = x <<< STATE_FRAC;
      la1 = longint'(low_a1);
      la2 = longint'(low_a2);
      ha1 = longint'(high_a1);
      ha2 = longint'(high_a2);

      lb  = round_shift((one + la1 + la2) * xs, CFB + 2);
      low = sat_to(lb + lp_z1[ch], STATE_WIDTH);
      lp_z1[ch] = sat_to(2 * lb - round_shift(la1 * low, CFB) + lp_z2[ch], STATE_WIDTH);
      lp_z2[ch] = sat_to(lb - round_shift(la2 * low, CFB), STATE_WIDTH);

      hb   = round_shift((one - ha1 + ha2) * xs, CFB + 2);
      high = sat_to(hb + hp_z1[ch], STATE_WIDTH);
      hp_z1[ch] = sat_to(-2 * hb - round_shift(ha1 * high, CFB) + hp_z2[ch], STATE_WIDTH);
      hp_z2[ch] = sat_to(hb - round_shift(ha2 * high, CFB), STATE_WIDTH);

      mid = xs - low - high;
      acc = longint'(gain_low) * low + longint'(gain_mid) * mid + longint'(gain_high) * high;
      return SW'(sat_to(round_shift(acc, GAIN_FRAC + STATE_FRAC), SW));
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // CSR write; the model bank follows once the write is accepted
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         REG_LOW_GAIN:      gain_low = value[GAIN_WIDTH-1:0];
         REG_MID_GAIN:      gain_mid = value[GAIN_WIDTH-1:0];
         REG_HIGH_GAIN:     gain_high = value[GAIN_WIDTH-1:0];
         REG_LOW_A1:        low_a1 = value[COEF_WIDTH-1:0];
         REG_LOW_A2:        low_a2 = value[COEF_WIDTH-1:0];
         REG_HIGH_A1:       high_a1 = value[COEF_WIDTH-1:0];
         REG_HIGH_A2:       high_a2 = value[COEF_WIDTH-1:0];
         REG_CHANNEL_COUNT: channel_count = value[COUNT_WIDTH-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_unknown_reg();
      write_reg(4'(REG_CHANNEL_COUNT) + 4'($urandom_range(1, 8)), CSR_DATA_WIDTH'($urandom));
   endtask

   task automatic queue_request(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
      pending_requests.push_back('{left: l, right: r});
      request_count++;
   endtask

   // wait until every request has come back, then let the block settle
   task automatic wait_drained();
      while (response_count < request_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // random feedback pair inside the biquad stability triangle
   task automatic pick_stable_pair(output logic signed [COEF_WIDTH-1:0] a1,
                                   output logic signed [COEF_WIDTH-1:0] a2);
      longint a2v, lim;
      a2v = longint'($urandom_range(0, 2 * A2_SPAN)) - A2_SPAN;
      lim = ONE_COEF + a2v - 100000;
      a1  = COEF_WIDTH'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
      a2  = COEF_WIDTH'(a2v);
   endtask

   // request driver: presents queued frames, predicts on acceptance
   always @(posedge clock) begin : driver
      logic next_valid;
      frame_type f, y;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            y.left  = req_left_in;
            y.right = req_right_in;
            if (channel_count != CH_NONE)
               y.left = isolate_channel(0, longint'(req_left_in));
            if (channel_count == CH_MONO)
               y.right = y.left;
            else if (channel_count != CH_NONE)
               y.right = isolate_channel(1, longint'(req_right_in));
            predicted_frames.push_back(y);
            next_valid = 1'b0;
         end
         if (!next_valid && pending_requests.size() != 0 &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            f = pending_requests.pop_front();
            req_left_in  <= f.left;
            req_right_in <= f.right;
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
      end
   end

   // response monitor: compares with the oldest prediction, stalls at random
   always @(posedge clock) begin : monitor
      frame_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_frames.size() == 0) begin
               report_error($sformatf("response with no request outstanding: L=%0d R=%0d",
                                      rsp_left_out, rsp_right_out));
            end else begin
               want = predicted_frames.pop_front();
               response_count++;
               if (rsp_left_out !== want.left)
                  report_error($sformatf("frame %0d left_out: got %0d want %0d",
                                         response_count, rsp_left_out, want.left));
               if (rsp_right_out !== want.right)
                  report_error($sformatf("frame %0d right_out: got %0d want %0d",
                                         response_count, rsp_right_out, want.right));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic signed [COEF_WIDTH-1:0] a1, a2;
      logic signed [SW-1:0] sl, sr;
      longint walk_l, walk_r, span;
      int kind;
      logic [COUNT_WIDTH-1:0] count_sel;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default stereo config, field extremes and bit patterns
      queue_request('0, '0);
      queue_request(SAMPLE_MAX, SAMPLE_MIN);
      queue_request(SAMPLE_MIN, SAMPLE_MAX);
      queue_request(SAMPLE_MAX, SAMPLE_MAX);
      queue_request(SAMPLE_MAX, SAMPLE_MAX);
      queue_request(SAMPLE_MIN, SAMPLE_MIN);
      queue_request(SW'(24'h555555), SW'(24'haaaaaa));
      queue_request(SW'(24'haaaaaa), SW'(24'h555555));
      queue_request(SW'(1), -SW'(1));
      wait_drained();

      // mono with gains above unity; an unknown index must be ignored
      write_reg(REG_CHANNEL_COUNT, CSR_DATA_WIDTH'(CH_MONO));
      write_reg(REG_LOW_GAIN, CSR_DATA_WIDTH'(GAIN_MAX));
      write_reg(REG_MID_GAIN, CSR_DATA_WIDTH'(98304));
      write_reg(REG_HIGH_GAIN, CSR_DATA_WIDTH'(GAIN_MAX));
      write_unknown_reg();
      queue_request(SAMPLE_MAX, SW'($urandom));
      queue_request(SAMPLE_MIN, SW'($urandom));
      queue_request(SAMPLE_MAX, SAMPLE_MIN);
      queue_request(SW'(3000000), SW'($urandom));
      wait_drained();

      // channel count zero: pass-through
      write_reg(REG_CHANNEL_COUNT, CSR_DATA_WIDTH'(CH_NONE));
      queue_request(SAMPLE_MAX, SAMPLE_MIN);
      queue_request(SW'($urandom), SW'($urandom));
      queue_request('0, -SW'(1));
      wait_drained();

      // channel count three behaves as stereo
      write_reg(REG_CHANNEL_COUNT, CSR_DATA_WIDTH'(CH_STEREO_ALIAS));
      queue_request(SAMPLE_MAX, SAMPLE_MIN);
      queue_request(SW'($urandom), SW'($urandom));
      queue_request(SAMPLE_MIN, SAMPLE_MAX);
      wait_drained();

      // random phases: new settings and idle pattern each time
      for (int p = 0; p < 8; p++) begin
         // gains
         if (p == 0) begin
            write_reg(REG_LOW_GAIN, CSR_DATA_WIDTH'(GAIN_UNITY));
            write_reg(REG_MID_GAIN, CSR_DATA_WIDTH'(GAIN_UNITY));
            write_reg(REG_HIGH_GAIN, CSR_DATA_WIDTH'(GAIN_UNITY));
         end else if (p == 3) begin
            write_reg(REG_LOW_GAIN, {7'($urandom), GAIN_MAX});
            write_reg(REG_MID_GAIN, {7'($urandom), {GAIN_WIDTH{1'b0}}});
            write_reg(REG_HIGH_GAIN, {7'($urandom), GAIN_MAX});
         end else begin
            write_reg(REG_LOW_GAIN, CSR_DATA_WIDTH'($urandom));
            write_reg(REG_MID_GAIN, CSR_DATA_WIDTH'($urandom));
            write_reg(REG_HIGH_GAIN, CSR_DATA_WIDTH'($urandom));
         end

         // feedback coefficients
         if (p == 0) begin
            write_reg(REG_LOW_A1, LOW_A1_RESET);
            write_reg(REG_LOW_A2, LOW_A2_RESET);
            write_reg(REG_HIGH_A1, HIGH_A1_RESET);
            write_reg(REG_HIGH_A2, HIGH_A2_RESET);
         end else if (p == 3) begin
            write_reg(REG_LOW_A1, COEF_MIN);
            write_reg(REG_LOW_A2, COEF_MAX);
            write_reg(REG_HIGH_A1, COEF_MAX);
            write_reg(REG_HIGH_A2, COEF_MIN);
         end else if (p == 5) begin
            write_reg(REG_LOW_A1, CSR_DATA_WIDTH'($urandom));
            write_reg(REG_LOW_A2, CSR_DATA_WIDTH'($urandom));
            write_reg(REG_HIGH_A1, CSR_DATA_WIDTH'($urandom));
            write_reg(REG_HIGH_A2, CSR_DATA_WIDTH'($urandom));
         end else begin
            pick_stable_pair(a1, a2);
            write_reg(REG_LOW_A1, a1);
            write_reg(REG_LOW_A2, a2);
            pick_stable_pair(a1, a2);
            write_reg(REG_HIGH_A1, a1);
            write_reg(REG_HIGH_A2, a2);
         end

         // channel count, with junk in the unused data bits
         case (p)
            1, 4:    count_sel = CH_MONO;
            5:       count_sel = CH_STEREO_ALIAS;
            6:       count_sel = CH_NONE;
            default: count_sel = CH_STEREO;
         endcase
         write_reg(REG_CHANNEL_COUNT, {22'($urandom), count_sel});
         write_unknown_reg();

         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
            default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
         endcase

         // mostly audio-like random walks, plus noise, extremes and tiny values
         walk_l = 0;
         walk_r = 0;
         span = longint'(1) <<< $urandom_range(4, 22);
         for (int i = 0; i < 212; i++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
               walk_l = sat_to(walk_l + longint'($urandom_range(0, 32'(2 * span))) - span, SW);
               walk_r = sat_to(walk_r + longint'($urandom_range(0, 32'(2 * span))) - span, SW);
               sl = SW'(walk_l);
               sr = SW'(walk_r);
            end else if (kind <= 7) begin
               sl = SW'($urandom);
               sr = SW'($urandom);
            end else if (kind == 8) begin
               case ($urandom_range(0, 3))
                  0: sl = SAMPLE_MAX;
                  1: sl = SAMPLE_MIN;
                  2: sl = '0;
                  default: sl = -SW'(1);
               endcase
               sr = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            end else begin
               sl = SW'($urandom_range(0, 64)) - SW'(32);
               sr = SW'($urandom_range(0, 64)) - SW'(32);
            end
            queue_request(sl, sr);
         end
         wait_drained();
         sender_idle_pct = 0;
         receiver_stall_pct = 0;
      end

      repeat (30) @(posedge clock);
      if (predicted_frames.size() != 0)
         report_error($sformatf("%0d predicted frames never returned",
                                predicted_frames.size()));
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
